// ----- rtl/tsem_pkg.sv -----
// ----------------------------------------------------------------------------
// tsem_pkg
// Types, widths and constants shared by the two-sphere enclosing merge block.
// ----------------------------------------------------------------------------
package tsem_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CRD_W      = 32;
	localparam int RAD_IN_W   = 31;
	localparam int RAD_OUT_W  = 32;
	localparam int THR_W      = 16;

	localparam int DIFF_W     = CRD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int NUM_W      = ROOT_W + 2;
	localparam int DIV_W      = ROOT_W + 2;
	localparam int T_W        = FRAC_BITS + 1;
	localparam int MAG_W      = DIFF_W + T_W;

	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;
	localparam logic REG_COINCIDE_THR = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	typedef struct packed {
		logic signed [CRD_W-1:0] first_center_x;
		logic signed [CRD_W-1:0] first_center_y;
		logic signed [CRD_W-1:0] first_center_z;
		logic [RAD_IN_W-1:0]     first_radius;
		logic signed [CRD_W-1:0] second_center_x;
		logic signed [CRD_W-1:0] second_center_y;
		logic signed [CRD_W-1:0] second_center_z;
		logic [RAD_IN_W-1:0]     second_radius;
	} sphere_pair_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] merged_center_x;
		logic signed [CRD_W-1:0] merged_center_y;
		logic signed [CRD_W-1:0] merged_center_z;
		logic [RAD_OUT_W-1:0]    merged_radius;
	} merged_t;

	// payload carried along the square root chain
	typedef struct packed {
		logic [2:0][CRD_W-1:0] c1;
		logic [2:0][CRD_W-1:0] c2;
		logic [RAD_IN_W-1:0]   r1;
		logic [RAD_IN_W-1:0]   r2;
	} sq_pl_t;

	// payload carried along the divider chain
	typedef struct packed {
		logic [2:0][CRD_W-1:0] c1;
		logic [2:0][CRD_W-1:0] c2;
		logic                  conc;
		logic [RAD_OUT_W-1:0]  rad;
		logic                  sat;
		logic                  zero;
	} div_pl_t;

endpackage

// ----- rtl/tsem_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tsem_sqrt_cell
// One digit step of the restoring square root, registered.
// ----------------------------------------------------------------------------
module tsem_sqrt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_i,
	input  logic [tsem_pkg::SUM_W-1:0]    rad_i,
	input  logic [tsem_pkg::REM_W-1:0]    rem_i,
	input  logic [tsem_pkg::ROOT_W-1:0]   root_i,
	input  tsem_pkg::sq_pl_t              pl_i,
	output logic                          v_q,
	output logic [tsem_pkg::SUM_W-1:0]    rad_q,
	output logic [tsem_pkg::REM_W-1:0]    rem_q,
	output logic [tsem_pkg::ROOT_W-1:0]   root_q,
	output tsem_pkg::sq_pl_t              pl_q
);

	logic [tsem_pkg::REM_W-1:0] rem_n;
	logic [tsem_pkg::REM_W-1:0] trial;
	logic                       ge;

	assign rem_n = {rem_i[tsem_pkg::REM_W-3:0], rad_i[tsem_pkg::SUM_W-1 -: 2]};
	assign trial = tsem_pkg::REM_W'({root_i, 2'b01});
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_i << 2;
			rem_q  <= ge ? rem_n - trial : rem_n;
			root_q <= {root_i[tsem_pkg::ROOT_W-2:0], ge};
			pl_q   <= pl_i;
		end
	end

endmodule

// ----- rtl/tsem_div_cell.sv -----
// ----------------------------------------------------------------------------
// tsem_div_cell
// One quotient bit of the restoring divider, registered.
// ----------------------------------------------------------------------------
module tsem_div_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            v_i,
	input  logic [tsem_pkg::DIV_W-1:0]      r_i,
	input  logic [tsem_pkg::DIV_W-1:0]      dv_i,
	input  logic [tsem_pkg::FRAC_BITS-1:0]  q_i,
	input  tsem_pkg::div_pl_t               pl_i,
	output logic                            v_q,
	output logic [tsem_pkg::DIV_W-1:0]      r_q,
	output logic [tsem_pkg::DIV_W-1:0]      dv_q,
	output logic [tsem_pkg::FRAC_BITS-1:0]  q_q,
	output tsem_pkg::div_pl_t               pl_q
);

	logic [tsem_pkg::DIV_W:0] r2;
	logic                     ge;

	assign r2 = {r_i, 1'b0};
	assign ge = r2 >= {1'b0, dv_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q  <= ge ? tsem_pkg::DIV_W'(r2 - {1'b0, dv_i}) : tsem_pkg::DIV_W'(r2);
			dv_q <= dv_i;
			q_q  <= {q_i[tsem_pkg::FRAC_BITS-2:0], ge};
			pl_q <= pl_i;
		end
	end

endmodule

// ----- rtl/two_sphere_enclosing_merge_top.sv -----
// ----------------------------------------------------------------------------
// two_sphere_enclosing_merge_top
// Smallest sphere enclosing two spheres, signed Q16.16, fully pipelined.
//
// Takes one sphere pair per clock while the output is not stalled. Each pair
// passes through a chain of 34 square root cells (one root bit each) and a
// chain of 16 divider cells (one fraction bit each), plus input, multiply,
// sum, setup, scale and output registers. All stages advance together; the
// pipeline holds only while the output register is full and not taken.
// coincide_threshold sits at byte address 0.
// ----------------------------------------------------------------------------
module two_sphere_enclosing_merge_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tsem_pkg::sphere_pair_t        in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tsem_pkg::merged_t             out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsem_pkg::APB_AW-1:0]   paddr,
	input  logic [tsem_pkg::APB_DW-1:0]   pwdata,
	output logic [tsem_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int N_SQ  = tsem_pkg::SQRT_STEPS;
	localparam int N_DV  = tsem_pkg::FRAC_BITS;
	localparam int CW    = tsem_pkg::CRD_W;
	localparam int DW    = tsem_pkg::DIFF_W;

	logic                      en;
	logic [tsem_pkg::THR_W-1:0] thr_q;

	// config port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tsem_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[tsem_pkg::APB_AW-1] == tsem_pkg::REG_COINCIDE_THR) begin
			thr_q <= pwdata[tsem_pkg::THR_W-1:0];
		end
	end
	always_comb begin
		unique case (paddr[tsem_pkg::APB_AW-1])
			tsem_pkg::REG_COINCIDE_THR: prdata = tsem_pkg::APB_DW'(thr_q);
			default:                    prdata = '0;
		endcase
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: absolute coordinate differences
	logic                    v_s1;
	logic [2:0][DW-1:0]      ad_s1;
	tsem_pkg::sq_pl_t        pl_s1;
	logic [2:0][CW-1:0]      in_c1;
	logic [2:0][CW-1:0]      in_c2;
	logic [2:0][DW-1:0]      in_df;

	assign in_c1 = {in_data.first_center_x, in_data.first_center_y,
		in_data.first_center_z};
	assign in_c2 = {in_data.second_center_x, in_data.second_center_y,
		in_data.second_center_z};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			in_df[k] = DW'($signed({in_c1[k][CW-1], in_c1[k]})
				- $signed({in_c2[k][CW-1], in_c2[k]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ad_s1[k] <= in_df[k][DW-1] ? DW'(-in_df[k]) : in_df[k];
			end
			pl_s1 <= '{c1: in_c1, c2: in_c2, r1: in_data.first_radius,
				r2: in_data.second_radius};
		end
	end

	// stage 2: squares
	logic                             v_s2;
	logic [2:0][tsem_pkg::SQ_W-1:0]   sq_s2;
	tsem_pkg::sq_pl_t                 pl_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= ad_s1[k] * ad_s1[k];
			end
			pl_s2 <= pl_s1;
		end
	end

	// stage 3: sum of squares
	logic                         v_s3;
	logic [tsem_pkg::SUM_W-1:0]   sum_s3;
	tsem_pkg::sq_pl_t             pl_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= tsem_pkg::SUM_W'(sq_s2[0]) + tsem_pkg::SUM_W'(sq_s2[1])
				+ tsem_pkg::SUM_W'(sq_s2[2]);
			pl_s3 <= pl_s2;
		end
	end

	// square root chain
	logic [N_SQ:0]                        sv;
	logic [tsem_pkg::SUM_W-1:0]           srad [N_SQ+1];
	logic [tsem_pkg::REM_W-1:0]           srem [N_SQ+1];
	logic [tsem_pkg::ROOT_W-1:0]          sroot[N_SQ+1];
	tsem_pkg::sq_pl_t                     spl  [N_SQ+1];

	assign sv[0]    = v_s3;
	assign srad[0]  = sum_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign spl[0]   = pl_s3;

	for (genvar i = 0; i < N_SQ; i++) begin : g_sq
		tsem_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (sv[i]),
			.rad_i (srad[i]),
			.rem_i (srem[i]),
			.root_i(sroot[i]),
			.pl_i  (spl[i]),
			.v_q   (sv[i+1]),
			.rad_q (srad[i+1]),
			.rem_q (srem[i+1]),
			.root_q(sroot[i+1]),
			.pl_q  (spl[i+1])
		);
	end

	// setup stage: radius, concentric test, divider operands
	logic [tsem_pkg::ROOT_W-1:0]       d;
	tsem_pkg::sq_pl_t                  dpl;
	logic signed [tsem_pkg::NUM_W-1:0] num;
	logic [tsem_pkg::DIV_W-1:0]        dd;
	logic                              num_zero;
	logic                              num_sat;
	logic                              conc;
	logic [tsem_pkg::ROOT_W:0]         rsum;
	logic [tsem_pkg::ROOT_W-1:0]       rhalf;
	logic [tsem_pkg::RAD_OUT_W-1:0]    rad_c;

	assign d   = sroot[N_SQ];
	assign dpl = spl[N_SQ];
	assign num = $signed(tsem_pkg::NUM_W'(d)) + $signed(tsem_pkg::NUM_W'(dpl.r2))
		- $signed(tsem_pkg::NUM_W'(dpl.r1));
	assign dd       = {1'b0, d, 1'b0};
	assign num_zero = num[tsem_pkg::NUM_W-1] || num == '0;
	assign num_sat  = !num_zero && tsem_pkg::DIV_W'(num) >= dd;
	assign conc     = d == '0 || d < tsem_pkg::ROOT_W'(thr_q);
	assign rsum     = (tsem_pkg::ROOT_W+1)'(d) + (tsem_pkg::ROOT_W+1)'(dpl.r1)
		+ (tsem_pkg::ROOT_W+1)'(dpl.r2);
	assign rhalf    = rsum[tsem_pkg::ROOT_W:1];

	always_comb begin
		if (conc) begin
			rad_c = dpl.r1 > dpl.r2 ? tsem_pkg::RAD_OUT_W'(dpl.r1)
				: tsem_pkg::RAD_OUT_W'(dpl.r2);
		end else if (|rhalf[tsem_pkg::ROOT_W-1:tsem_pkg::RAD_OUT_W]) begin
			rad_c = '1;
		end else begin
			rad_c = rhalf[tsem_pkg::RAD_OUT_W-1:0];
		end
	end

	logic [N_DV:0]                        dvv;
	logic [tsem_pkg::DIV_W-1:0]           dvr  [N_DV+1];
	logic [tsem_pkg::DIV_W-1:0]           dvd  [N_DV+1];
	logic [tsem_pkg::FRAC_BITS-1:0]       dvq  [N_DV+1];
	tsem_pkg::div_pl_t                    dvpl [N_DV+1];

	logic                        v_p;
	logic [tsem_pkg::DIV_W-1:0]  r_p;
	logic [tsem_pkg::DIV_W-1:0]  dd_p;
	tsem_pkg::div_pl_t           pl_p;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= sv[N_SQ];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_p  <= (num_zero || num_sat) ? '0 : tsem_pkg::DIV_W'(num);
			dd_p <= dd;
			pl_p <= '{c1: dpl.c1, c2: dpl.c2, conc: conc, rad: rad_c,
				sat: num_sat, zero: num_zero};
		end
	end

	assign dvv[0]  = v_p;
	assign dvr[0]  = r_p;
	assign dvd[0]  = dd_p;
	assign dvq[0]  = '0;
	assign dvpl[0] = pl_p;

	for (genvar j = 0; j < N_DV; j++) begin : g_dv
		tsem_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (dvv[j]),
			.r_i   (dvr[j]),
			.dv_i  (dvd[j]),
			.q_i   (dvq[j]),
			.pl_i  (dvpl[j]),
			.v_q   (dvv[j+1]),
			.r_q   (dvr[j+1]),
			.dv_q  (dvd[j+1]),
			.q_q   (dvq[j+1]),
			.pl_q  (dvpl[j+1])
		);
	end

	// scale stage: |c2-c1| * t and midpoint
	tsem_pkg::div_pl_t         qpl;
	logic [tsem_pkg::T_W-1:0]  t;
	logic [2:0][DW-1:0]        ldf;
	logic [2:0][DW-1:0]        lsm;

	assign qpl = dvpl[N_DV];
	always_comb begin
		if (qpl.sat) begin
			t = tsem_pkg::T_W'(1) << tsem_pkg::FRAC_BITS;
		end else if (qpl.zero) begin
			t = '0;
		end else begin
			t = tsem_pkg::T_W'(dvq[N_DV]);
		end
		for (int k = 0; k < 3; k++) begin
			ldf[k] = DW'($signed({qpl.c2[k][CW-1], qpl.c2[k]})
				- $signed({qpl.c1[k][CW-1], qpl.c1[k]}));
			lsm[k] = DW'($signed({qpl.c2[k][CW-1], qpl.c2[k]})
				+ $signed({qpl.c1[k][CW-1], qpl.c1[k]}));
		end
	end

	logic                               v_l1;
	logic [2:0][tsem_pkg::MAG_W-1:0]    mag_l1;
	logic [2:0]                         neg_l1;
	logic [2:0][CW-1:0]                 c1_l1;
	logic [2:0][CW-1:0]                 mid_l1;
	logic                               conc_l1;
	logic [tsem_pkg::RAD_OUT_W-1:0]     rad_l1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_l1 <= 1'b0;
		end else if (en) begin
			v_l1 <= dvv[N_DV];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mag_l1[k] <= tsem_pkg::MAG_W'(ldf[k][DW-1] ? DW'(-ldf[k]) : ldf[k])
					* tsem_pkg::MAG_W'(t);
				neg_l1[k] <= ldf[k][DW-1];
				mid_l1[k] <= lsm[k][DW-1:1];
			end
			c1_l1   <= qpl.c1;
			conc_l1 <= qpl.conc;
			rad_l1  <= qpl.rad;
		end
	end

	// output register: round half away from zero and apply the offset
	logic [2:0][tsem_pkg::MAG_W-1:0] rnd;
	logic [2:0][CW-1:0]              crd;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd[k] = (mag_l1[k] + (tsem_pkg::MAG_W'(1) << (tsem_pkg::FRAC_BITS - 1)))
				>> tsem_pkg::FRAC_BITS;
			if (conc_l1) begin
				crd[k] = mid_l1[k];
			end else if (neg_l1[k]) begin
				crd[k] = c1_l1[k] - rnd[k][CW-1:0];
			end else begin
				crd[k] = c1_l1[k] + rnd[k][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_l1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= '{merged_center_x: crd[2], merged_center_y: crd[1],
				merged_center_z: crd[0], merged_radius: rad_l1};
		end
	end

endmodule

// ----- rtl/tsem_checker.sv -----
// ----------------------------------------------------------------------------
// tsem_checker
// Port-level checks on handshake flow and the configuration port.
// ----------------------------------------------------------------------------
module tsem_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input tsem_pkg::merged_t             out_data,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [tsem_pkg::APB_AW-1:0]   paddr,
	input logic [tsem_pkg::APB_DW-1:0]   pwdata,
	input logic [tsem_pkg::APB_DW-1:0]   prdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a stalled output blocks new items
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// an empty output never blocks the input
	a_free_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a threshold write reads back
	a_cfg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == '0 ##1 psel && !pwrite && paddr == '0
		|-> prdata == tsem_pkg::APB_DW'($past(pwdata[tsem_pkg::THR_W-1:0])))
		else $error("threshold readback mismatch");

endmodule

bind two_sphere_enclosing_merge_top tsem_checker u_tsem_checker (.*);
